@@ src/fpr_pkg.sv @@
`default_nettype none

package fpr_pkg;

  localparam int unsigned BYTE_W = 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_VALUE = 2'd0,
    CFG_TOOL_ADDRESS = 2'd1,
    CFG_UNIT_ADDRESS = 2'd2,
    CFG_ECHO_MODE    = 2'd3
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] HEADER_VALUE_RST = 8'd128;
  localparam logic [BYTE_W-1:0] TOOL_ADDRESS_RST = 8'd240;
  localparam logic [BYTE_W-1:0] UNIT_ADDRESS_RST = 8'd16;
  localparam logic              ECHO_MODE_RST    = 1'b0;

  // One result beat before packing onto the output port
  typedef struct packed {
    logic [BYTE_W-1:0] payload_size;
    logic [BYTE_W-1:0] payload_index;
    logic [BYTE_W-1:0] payload_byte;
  } out_data_t;

  localparam int unsigned OUT_DATA_W = $bits(out_data_t);

endpackage

`default_nettype wire

@@ src/framed_packet_receiver_top.sv @@
`default_nettype none
// Result: a result beat is registered and appears on out_* in the cycle after the data or checksum beat is taken.
// Throughput: one input beat per cycle; the only stall is a full result register that the
//   downstream side does not take in the same cycle.
// Reset (rst_n low, synchronous): parser back to header hunt, sums and counts cleared,
//   result register emptied, configuration registers back to their documented defaults.
module framed_packet_receiver_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    cfg_wdata,
  // received byte stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] rx_byte
  // payload / frame end stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [fpr_pkg::OUT_DATA_W-1:0]     out_tdata,  // [7:0] payload_byte,
                                                         // [15:8] payload_index,
                                                         // [23:16] payload_size
  output logic                               out_tlast,  // frame_end
  output logic                               out_tuser   // sum_ok
);

  import fpr_pkg::*;

  // Frame parser phases; unused codes fall back to the header hunt
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_DEST = 3'd1,
    PH_SRC  = 3'd2,
    PH_SIZE = 3'd3,
    PH_BODY = 3'd4,
    PH_CSUM = 3'd5
  } phase_t;

  // configuration registers
  logic [BYTE_W-1:0] header_value_r;
  logic [BYTE_W-1:0] tool_address_r;
  logic [BYTE_W-1:0] unit_address_r;
  logic              echo_mode_r;

  // parser state
  phase_t            phase_r,       phase_nxt;
  logic [BYTE_W-1:0] running_sum_r, running_sum_nxt;
  logic [BYTE_W-1:0] body_length_r, body_length_nxt;
  logic [BYTE_W-1:0] body_count_r,  body_count_nxt;

  // result register
  logic              out_valid_r;
  out_data_t         out_data_r,    out_data_nxt;
  logic              out_last_r,    out_last_nxt;
  logic              out_ok_r,      out_ok_nxt;

  logic              emit;          // accepted beat produces a result
  logic              in_fire;
  logic [BYTE_W-1:0] want_dest;
  logic [BYTE_W-1:0] want_src;
  logic [BYTE_W-1:0] sum_add;
  logic [BYTE_W-1:0] count_inc;

  // The result register can take a new beat when empty or draining this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Echo mode swaps which side is expected as destination and source.
  assign want_dest = echo_mode_r ? unit_address_r : tool_address_r;
  assign want_src  = echo_mode_r ? tool_address_r : unit_address_r;
  assign sum_add   = running_sum_r + in_tdata;   // 8-bit wrapping sum
  assign count_inc = body_count_r + 8'd1;

  always_comb begin
    phase_nxt       = phase_r;
    running_sum_nxt = running_sum_r;
    body_length_nxt = body_length_r;
    body_count_nxt  = body_count_r;
    emit            = 1'b0;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;
    out_ok_nxt      = out_ok_r;

    case (phase_r)
      PH_DEST: begin
        // a wrong address drops the frame; this byte is not retried as a header
        if (in_tdata == want_dest) begin
          running_sum_nxt = sum_add;
          phase_nxt       = PH_SRC;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_SRC: begin
        if (in_tdata == want_src) begin
          running_sum_nxt = sum_add;
          phase_nxt       = PH_SIZE;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_SIZE: begin
        running_sum_nxt = sum_add;
        body_length_nxt = in_tdata;
        body_count_nxt  = '0;
        // empty body goes straight to the checksum byte
        phase_nxt       = (in_tdata == '0) ? PH_CSUM : PH_BODY;
      end
      PH_BODY: begin
        running_sum_nxt            = sum_add;
        emit                       = 1'b1;
        out_data_nxt.payload_byte  = in_tdata;
        out_data_nxt.payload_index = body_count_r;
        out_data_nxt.payload_size  = body_length_r;
        out_last_nxt               = 1'b0;
        out_ok_nxt                 = 1'b0;
        body_count_nxt             = count_inc;
        if (count_inc == body_length_r) begin
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        emit                       = 1'b1;
        out_data_nxt.payload_byte  = in_tdata;
        out_data_nxt.payload_index = '0;
        out_data_nxt.payload_size  = body_length_r;
        out_last_nxt               = 1'b1;
        out_ok_nxt                 = (in_tdata == running_sum_r);
        phase_nxt                  = PH_HUNT;
      end
      default: begin
        // header hunt: the sum restarts from the header byte
        if (in_tdata == header_value_r) begin
          running_sum_nxt = in_tdata;
          phase_nxt       = PH_DEST;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_value_r <= HEADER_VALUE_RST;
      tool_address_r <= TOOL_ADDRESS_RST;
      unit_address_r <= UNIT_ADDRESS_RST;
      echo_mode_r    <= ECHO_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HEADER_VALUE: header_value_r <= cfg_wdata;
        CFG_TOOL_ADDRESS: tool_address_r <= cfg_wdata;
        CFG_UNIT_ADDRESS: unit_address_r <= cfg_wdata;
        CFG_ECHO_MODE:    echo_mode_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      running_sum_r <= '0;
      body_length_r <= '0;
      body_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r       <= phase_nxt;
        running_sum_r <= running_sum_nxt;
        body_length_r <= body_length_nxt;
        body_count_r  <= body_count_nxt;
      end
      if (in_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload side needs no reset
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
      out_ok_r   <= out_ok_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ok_r;

endmodule

`default_nettype wire
